// ===== sv/ces_pkg.sv =====
// Shared types, character constants and the byte classifier for the escape encoder.
`default_nettype none

package ces_pkg;

    localparam int CES_MAX_CHARS   = 5;
    localparam int CES_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_X = 8'h78;

    // One classified request: the characters to emit and the index of the last one.
    typedef struct packed {
        logic [CES_MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                    last_idx;
    } t_ces_cmd;

    function automatic logic [7:0] ces_hex(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {4'd0, d};
        end else begin
            r = CH_LOW_A + {4'd0, d} - 8'd10;
        end
        return r;
    endfunction

    function automatic t_ces_cmd ces_classify(input logic [7:0] c, input logic fin,
                                              input logic no_trig);
        t_ces_cmd   cmd;
        logic [7:0] trig_ch;
        logic       trig_hit;
        logic [7:0] ctl_ch;
        logic       ctl_hit;
        logic [2:0] n;

        trig_hit = 1'b1;
        unique case (c)
            8'h5B:   trig_ch = 8'h28; // [ -> (
            8'h5C:   trig_ch = 8'h2F; // \ -> /
            8'h5D:   trig_ch = 8'h29; // ] -> )
            8'h5E:   trig_ch = 8'h27; // ^ -> '
            8'h7B:   trig_ch = 8'h3C; // { -> <
            8'h7C:   trig_ch = 8'h21; // | -> !
            8'h7D:   trig_ch = 8'h3E; // } -> >
            8'h7E:   trig_ch = 8'h2D; // ~ -> -
            8'h23:   trig_ch = 8'h3D; // # -> =
            default: begin
                trig_ch  = CH_NUL;
                trig_hit = 1'b0;
            end
        endcase

        ctl_hit = 1'b1;
        unique case (c)
            CH_DQUOT: ctl_ch = CH_DQUOT;
            CH_BSL:   ctl_ch = CH_BSL;
            CH_BEL:   ctl_ch = 8'h61; // a
            CH_BS:    ctl_ch = 8'h62; // b
            CH_FF:    ctl_ch = 8'h66; // f
            CH_LF:    ctl_ch = 8'h6E; // n
            CH_CR:    ctl_ch = 8'h72; // r
            CH_HT:    ctl_ch = 8'h74; // t
            CH_VT:    ctl_ch = 8'h76; // v
            default:  begin
                ctl_ch  = CH_NUL;
                ctl_hit = 1'b0;
            end
        endcase

        cmd.chars = '0;
        if (!no_trig && trig_hit) begin
            cmd.chars[0] = CH_QMARK;
            cmd.chars[1] = CH_QMARK;
            cmd.chars[2] = trig_ch;
            n = 3'd3;
        end else if (!no_trig && c == CH_QMARK) begin
            cmd.chars[0] = CH_BSL;
            cmd.chars[1] = CH_QMARK;
            n = 3'd2;
        end else if (ctl_hit) begin
            cmd.chars[0] = CH_BSL;
            cmd.chars[1] = ctl_ch;
            n = 3'd2;
        end else if (c >= CH_SPACE && c <= CH_TILDE) begin
            cmd.chars[0] = c;
            n = 3'd1;
        end else if (c == CH_NUL) begin
            cmd.chars[0] = CH_BSL;
            cmd.chars[1] = CH_ZERO;
            n = 3'd2;
        end else begin
            cmd.chars[0] = CH_BSL;
            cmd.chars[1] = CH_LOW_X;
            if (c[7:4] != 4'd0) begin
                cmd.chars[2] = ces_hex(c[7:4]);
                cmd.chars[3] = ces_hex(c[3:0]);
                n = 3'd4;
            end else begin
                cmd.chars[2] = ces_hex(c[3:0]);
                n = 3'd3;
            end
        end
        // terminator slot is already zero; just extend the run
        if (fin) begin
            n = n + 3'd1;
        end
        cmd.last_idx = n - 3'd1;
        return cmd;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ces_if.sv =====
// Valid/ready channel interfaces for raw input bytes and escaped output characters.
`default_nettype none

interface ces_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source(output valid, output in_byte, output final_byte, input ready);
    modport sink(input valid, input in_byte, input final_byte, output ready);
endinterface

interface ces_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;

    modport source(output valid, output out_char, output run_last, input ready);
    modport sink(input valid, input out_char, input run_last, output ready);
endinterface

`default_nettype wire

// ===== sv/ces_front.sv =====
// Front end: config register, input request acceptance and byte classification.
`default_nettype none

module ces_front
    import ces_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    ces_in_if.sink        i_in_ch,
    output t_ces_cmd      o_push_cmd,
    output logic          o_push_valid,
    input  wire logic     i_push_ready
);

    logic r_no_trigraphs;
    logic n_no_trigraphs;

    always_comb begin
        n_no_trigraphs = r_no_trigraphs;
        if (i_cfg_we) begin
            n_no_trigraphs = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_trigraphs <= 1'b0;
        end else begin
            r_no_trigraphs <= n_no_trigraphs;
        end
    end

    assign i_in_ch.ready = i_push_ready;
    assign o_push_valid  = i_in_ch.valid;
    assign o_push_cmd    = ces_classify(i_in_ch.in_byte, i_in_ch.final_byte, r_no_trigraphs);

endmodule

`default_nettype wire

// ===== sv/ces_queue.sv =====
// Small FIFO of classified requests between the front and back ends.
`default_nettype none

module ces_queue
    import ces_pkg::*;
#(
    parameter int DEPTH = CES_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push_valid,
    input  wire t_ces_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output t_ces_cmd      o_pop_cmd,
    input  wire logic     i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_ces_cmd      r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          push;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty request queue");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("request queue count overflow");

endmodule

`default_nettype wire

// ===== sv/ces_back.sv =====
// Back end: walks the head request one character per cycle, unless output stalls, into the output register.
`default_nettype none

module ces_back
    import ces_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cmd_valid,
    input  wire t_ces_cmd i_cmd,
    output logic          o_pop,
    ces_out_if.source     o_out_ch
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic       load;
    logic       at_last;

    // output slot is free when empty or being taken this cycle
    assign load    = i_cmd_valid && (!r_valid || o_out_ch.ready);
    assign at_last = (r_idx == i_cmd.last_idx);
    assign o_pop   = load && at_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        if (o_out_ch.ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_char  = i_cmd.chars[r_idx];
            n_last  = at_last;
            n_idx   = at_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_ch.valid    = r_valid;
    assign o_out_ch.out_char = r_char;
    assign o_out_ch.run_last = r_last;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (r_idx <= i_cmd.last_idx))
        else $error("character index past end of request");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_valid |-> (r_idx == 3'd0))
        else $error("character index nonzero with no request pending");

endmodule

`default_nettype wire

// ===== sv/c_escape_sequence_encoder.sv =====
// Top level of the C string-literal escape encoder.
//
//  channel    dir  payload                     handshake
//  i_in_ch    in   in_byte[7:0], final_byte    valid/ready
//  o_out_ch   out  out_char[7:0], run_last     valid/ready
//  i_cfg_*    in   i_cfg_wdata (no_trigraphs)  i_cfg_we
//
// Each input request yields 1 to 5 output characters, one per cycle while the receiver
// is ready; the output register sets the sustained rate at one character per cycle.
// An accepted request is written to the queue, then its first character to the output register.
// The request queue (QUEUE_DEPTH entries) lets input be taken while output stalls.
// Reset is synchronous, active low, and clears no_trigraphs and the queue.
`default_nettype none

module c_escape_sequence_encoder
    import ces_pkg::*;
#(
    parameter int QUEUE_DEPTH = CES_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    ces_in_if.sink    i_in_ch,
    ces_out_if.source o_out_ch
);

    t_ces_cmd push_cmd;
    t_ces_cmd head_cmd;
    logic     push_valid;
    logic     push_ready;
    logic     head_valid;
    logic     pop;

    ces_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_ch      (i_in_ch),
        .o_push_cmd   (push_cmd),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready)
    );

    ces_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (head_valid),
        .o_pop_cmd    (head_cmd),
        .i_pop        (pop)
    );

    ces_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_ch    (o_out_ch)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for c_escape_sequence_encoder: random byte stream against an own predictor.
`timescale 1ns / 100ps

module testbench;
    import ces_pkg::*;

    localparam int          CLK_HALF_NS  = 10;
    localparam int          RESET_CYCLES = 10;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD    = 200;
    localparam int          RAND_ITEMS   = 80;
    localparam int          N_CORNERS    = 25;
    localparam longint      TIMEOUT_NS   = 10_000_000;
    localparam logic        TRIG_ON      = 1'b0;
    localparam logic        TRIG_OFF     = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_raw_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_esc_char;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ces_in_if  raw_ch();
    ces_out_if esc_ch();

    c_escape_sequence_encoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_ch     (raw_ch),
        .o_out_ch    (esc_ch)
    );

    t_raw_req    raw_bytes_q[$];
    t_esc_char   esc_chars_q[$];
    int          bytes_outstanding = 0;
    int          mismatch_count    = 0;
    logic        no_trig_model     = TRIG_ON;
    logic        req_taken         = 1'b0;
    logic        src_idle_on       = 1'b1;
    logic        snk_idle_on       = 1'b1;
    logic        hold_req          = 1'b0;
    int          src_gap           = 0;
    int          snk_gap           = 0;
    int          hold_cnt          = 0;

    always #(CLK_HALF_NS) clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] trigraph_tail(input logic [7:0] c);
        case (c)
            "[":      return "(";
            CH_BSL:   return "/";
            "]":      return ")";
            "^":      return "'";
            "{":      return "<";
            "|":      return "!";
            "}":      return ">";
            CH_TILDE: return "-";
            "#":      return "=";
            default:  return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] control_letter(input logic [7:0] c);
        case (c)
            CH_DQUOT: return CH_DQUOT;
            CH_BSL:   return CH_BSL;
            CH_BEL:   return "a";
            CH_BS:    return "b";
            CH_FF:    return "f";
            CH_LF:    return "n";
            CH_CR:    return "r";
            CH_HT:    return "t";
            CH_VT:    return "v";
            default:  return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end
        return CH_LOW_A + {4'd0, d} - 8'd10;
    endfunction

    // Expected escaped spelling of one raw byte, appended to esc_chars_q.
    function automatic void predict_escape(input logic [7:0] c, input logic fin);
        logic [7:0] seq[$];
        logic [7:0] tri_ch;
        logic [7:0] ctl_ch;
        tri_ch = trigraph_tail(c);
        ctl_ch = control_letter(c);
        if (!no_trig_model && tri_ch != CH_NUL) begin
            seq.push_back(CH_QMARK);
            seq.push_back(CH_QMARK);
            seq.push_back(tri_ch);
        end else if (!no_trig_model && c == CH_QMARK) begin
            seq.push_back(CH_BSL);
            seq.push_back(CH_QMARK);
        end else if (ctl_ch != CH_NUL) begin
            seq.push_back(CH_BSL);
            seq.push_back(ctl_ch);
        end else if (c >= CH_SPACE && c <= CH_TILDE) begin
            seq.push_back(c);
        end else if (c == CH_NUL) begin
            seq.push_back(CH_BSL);
            seq.push_back(CH_ZERO);
        end else begin
            seq.push_back(CH_BSL);
            seq.push_back(CH_LOW_X);
            if (c[7:4] != 4'd0) begin
                seq.push_back(hex_char(c[7:4]));
            end
            seq.push_back(hex_char(c[3:0]));
        end
        if (fin) begin
            seq.push_back(CH_NUL);
        end
        foreach (seq[i]) begin
            esc_chars_q.push_back(t_esc_char'{out_char: seq[i],
                                              run_last: (i == seq.size() - 1)});
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [7:0] corner_byte(input int k);
        case (k)
            0:       return CH_NUL;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return 8'h01;
            5:       return 8'h0F;
            6:       return "[";
            7:       return CH_BSL;
            8:       return "]";
            9:       return "^";
            10:      return "{";
            11:      return "|";
            12:      return "}";
            13:      return CH_TILDE;
            14:      return "#";
            15:      return CH_QMARK;
            16:      return CH_DQUOT;
            17:      return CH_BEL;
            18:      return CH_BS;
            19:      return CH_HT;
            20:      return CH_LF;
            21:      return CH_VT;
            22:      return CH_FF;
            23:      return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] rand_raw_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return corner_byte($urandom_range(0, N_CORNERS - 1));
        end else if (r < 7) begin
            return 8'($urandom_range(CH_SPACE, CH_TILDE));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 92) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    task automatic queue_byte(input logic [7:0] c, input logic fin);
        raw_bytes_q.push_back(t_raw_req'{in_byte: c, final_byte: fin});
        bytes_outstanding++;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            queue_byte(rand_raw_byte(), ($urandom_range(0, 5) == 0));
        end
    endtask

    // Hold the sender until every request was taken and every character came out.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (bytes_outstanding != 0 || esc_chars_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_no_trig(input logic v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        no_trig_model = v;
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk) begin : take_req
        if (rst_n && raw_ch.valid && raw_ch.ready) begin
            predict_escape(raw_ch.in_byte, raw_ch.final_byte);
            bytes_outstanding--;
            req_taken = 1'b1;
        end else begin
            req_taken = 1'b0;
        end
    end

    always @(negedge clk) begin : drive_req
        logic     nxt_valid;
        t_raw_req req;
        nxt_valid = raw_ch.valid;
        if (rst_n && (!raw_ch.valid || req_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                nxt_valid = 1'b0;
            end else if (raw_bytes_q.size() != 0) begin
                req = raw_bytes_q.pop_front();
                nxt_valid = 1'b1;
                raw_ch.in_byte    <= req.in_byte;
                raw_ch.final_byte <= req.final_byte;
                if (src_idle_on && $urandom_range(0, 3) == 0) begin
                    src_gap = pick_gap();
                end
            end else begin
                nxt_valid = 1'b0;
            end
        end
        raw_ch.valid <= nxt_valid;
    end

    // ---------------------------------------------------------------- receiver

    always @(negedge clk) begin : drive_ready
        logic nxt_ready;
        if (hold_cnt > 0) begin
            hold_cnt--;
            nxt_ready = 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = LONG_HOLD - 1;
            nxt_ready = 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            nxt_ready = 1'b0;
        end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
            snk_gap = pick_gap() - 1;
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = 1'b1;
        end
        esc_ch.ready <= nxt_ready;
    end

    always @(posedge clk) begin : check_chars
        t_esc_char want;
        if (rst_n && esc_ch.valid && esc_ch.ready) begin
            if (esc_chars_q.size() == 0) begin
                $error("unexpected character: out_char %h run_last %b",
                       esc_ch.out_char, esc_ch.run_last);
                mismatch_count++;
            end else begin
                want = esc_chars_q.pop_front();
                if (esc_ch.out_char !== want.out_char) begin
                    $error("out_char: expected %h, actual %h", want.out_char, esc_ch.out_char);
                    mismatch_count++;
                end
                if (esc_ch.run_last !== want.run_last) begin
                    $error("run_last: expected %b, actual %b", want.run_last, esc_ch.run_last);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        raw_ch.valid      = 1'b0;
        raw_ch.in_byte    = 8'h00;
        raw_ch.final_byte = 1'b0;
        esc_ch.ready      = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // trigraphs on: every class and the byte-range edges
        write_no_trig(TRIG_ON);
        for (int k = 0; k < N_CORNERS; k++) begin
            queue_byte(corner_byte(k), (k % 4 == 3) || (k == N_CORNERS - 1));
        end
        wait_idle();

        // trigraphs off: former trigraph chars and ? lose their trigraph escapes
        write_no_trig(TRIG_OFF);
        queue_byte("[", 1'b0);
        queue_byte(CH_BSL, 1'b0);
        queue_byte("#", 1'b1);
        queue_byte(CH_TILDE, 1'b0);
        queue_byte(CH_QMARK, 1'b0);
        queue_byte(CH_DQUOT, 1'b1);
        wait_idle();

        // random, with one long receiver hold while requests keep coming
        write_no_trig(TRIG_ON);
        queue_random(RAND_ITEMS);
        while (raw_bytes_q.size() > RAND_ITEMS - 20) @(negedge clk);
        @(posedge clk);
        hold_req = 1'b1;
        wait_idle();

        write_no_trig(TRIG_OFF);
        queue_random(RAND_ITEMS);
        wait_idle();

        // back to back, no idling on either side
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        write_no_trig(TRIG_ON);
        queue_random(RAND_ITEMS);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ces_pkg.sv
sv/ces_if.sv
sv/ces_front.sv
sv/ces_queue.sv
sv/ces_back.sv
sv/c_escape_sequence_encoder.sv
bench/testbench.sv
